// ===== rtl/core/bnnd_pkg.sv =====
// Shared types and constants for the Bayer nearest-neighbour demosaic.
`default_nettype none
package bnnd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;

  localparam int WIDTH_BITS  = 13;
  localparam int HEIGHT_BITS = 16;
  localparam int PIX_BITS    = 8;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 16'd480;
  localparam logic                   MODE_RST   = 1'b1;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_INTERP_MODE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                frame_end;
    logic                run_last;
    logic [PIX_BITS-1:0] blue;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] red;
  } pix_t;

endpackage
`default_nettype wire

// ===== rtl/core/bnnd_line_buf.sv =====
// Single-port read-first line buffer holding the previous raw row.
`default_nettype none
module bnnd_line_buf #(
  parameter int DEPTH = bnnd_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [AW-1:0]                 addr,
  input  wire logic [bnnd_pkg::PIX_BITS-1:0] wdata,
  output logic      [bnnd_pkg::PIX_BITS-1:0] rdata
);

  logic [bnnd_pkg::PIX_BITS-1:0] mem [DEPTH];
  logic [bnnd_pkg::PIX_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r   <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/bnnd_out_q.sv =====
// Two-entry result queue between the demosaic stage and the output stream.
`default_nettype none
module bnnd_out_q (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bnnd_pkg::pix_t push_data,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bnnd_pkg::pix_t      out_data
);

  bnnd_pkg::pix_t ent_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bayer_nearest_neighbour_demosaic_top.sv =====
// Top level of the GRBG nearest-neighbour Bayer demosaic.
//
//  Channel  Direction  Handshake             Payload
//  in_      slave      in_tvalid/in_tready   tdata = raw_pixel
//  out_     master     out_tvalid/out_tready tdata = red,green,blue; tlast; tuser
//  cfg_     slave      APB write/read        image_width, image_height, interp_mode
//
//  One raw pixel per cycle is accepted; each request is registered in the demosaic stage
//  and its results in the output queue. Row 1, and column 1 of even rows but row 0, make
//  two results per request, pushed one per cycle, so the input waits for the second push.
//  A full output queue holds the stage and drops in_tready. The line buffer is read and
//  written once per request. rst_n is synchronous; it resets position, neighbour registers
//  and configuration. The line buffer has no reset; the user, not it, keeps reads on written entries.
`default_nettype none
module bayer_nearest_neighbour_demosaic_top #(
  parameter int MAX_WIDTH = bnnd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] raw_pixel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [23:0]                             out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                                    out_tlast,
  output logic                                    out_tuser,  // [0] frame_end
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [bnnd_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [bnnd_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic      [bnnd_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int XW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > bnnd_pkg::WIDTH_BITS) ?
                       $clog2(MAX_WIDTH + 1) : bnnd_pkg::WIDTH_BITS;
  localparam int HB  = bnnd_pkg::HEIGHT_BITS;
  localparam int PB  = bnnd_pkg::PIX_BITS;

  typedef enum logic [1:0] {
    OWN_RED   = 2'd0,
    OWN_GREEN = 2'd1,
    OWN_BLUE  = 2'd2
  } own_t;

  typedef struct packed {
    logic [PB-1:0] red;
    logic [PB-1:0] green;
    logic [PB-1:0] blue;
    own_t          own;
  } rgb_t;

  // configuration
  logic [bnnd_pkg::WIDTH_BITS-1:0] width_r;
  logic [HB-1:0]                   height_r;
  logic                            mode_r;
  bnnd_pkg::cfg_reg_t              cfg_idx;
  logic                            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = bnnd_pkg::cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      bnnd_pkg::REG_IMAGE_WIDTH:
        cfg_prdata = {{(bnnd_pkg::CFG_DATA_BITS-bnnd_pkg::WIDTH_BITS){1'b0}}, width_r};
      bnnd_pkg::REG_IMAGE_HEIGHT:
        cfg_prdata = {{(bnnd_pkg::CFG_DATA_BITS-HB){1'b0}}, height_r};
      bnnd_pkg::REG_INTERP_MODE:
        cfg_prdata = {{(bnnd_pkg::CFG_DATA_BITS-1){1'b0}}, mode_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bnnd_pkg::WIDTH_RST;
      height_r <= bnnd_pkg::HEIGHT_RST;
      mode_r   <= bnnd_pkg::MODE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bnnd_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[bnnd_pkg::WIDTH_BITS-1:0];
        bnnd_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[HB-1:0];
        bnnd_pkg::REG_INTERP_MODE:  mode_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // position and request stage
  logic [XW-1:0]  col_r, col_nxt;
  logic [HB-1:0]  row_r, row_nxt;
  logic [PB-1:0]  lc_r;
  logic [PB-1:0]  la_r;
  logic [PB-1:0]  r1_r;
  logic [WCW-1:0] w_eff;
  logic [HB-1:0]  h_eff;
  logic [XW-1:0]  x;
  logic [HB-1:0]  y;
  logic [WCW-1:0] x_inc;
  logic [HB:0]    y_inc;
  logic           wrap;
  logic           row_wrap;
  logic           accept;
  logic [PB-1:0]  v;

  assign v      = in_tdata[PB-1:0];
  assign accept = in_tvalid && in_tready;

  always_comb begin
    if (WCW'(width_r) < WCW'(2)) begin
      w_eff = WCW'(2);
    end else if (WCW'(width_r) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(width_r);
    end
    h_eff    = (height_r < HB'(2)) ? HB'(2) : height_r;
    x        = (WCW'(col_r) >= w_eff) ? '0 : col_r;
    y        = (row_r >= h_eff) ? '0 : row_r;
    x_inc    = WCW'(x) + WCW'(1);
    y_inc    = {1'b0, y} + (HB+1)'(1);
    wrap     = (x_inc >= w_eff);
    row_wrap = (y_inc >= {1'b0, h_eff});
    col_nxt  = wrap ? '0 : x_inc[XW-1:0];
    if (!wrap) begin
      row_nxt = y;
    end else if (row_wrap) begin
      row_nxt = '0;
    end else begin
      row_nxt = y_inc[HB-1:0];
    end
  end

  logic [PB-1:0] a;

  bnnd_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_line_buf (
    .clk   (clk),
    .en    (accept),
    .addr  (x),
    .wdata (v),
    .rdata (a)
  );

  // demosaic stage
  logic          s1_v_r;
  logic          phase_r;
  logic [PB-1:0] s1_pix_r;
  logic [PB-1:0] s1_lc_r;
  logic [PB-1:0] s1_r1_r;
  logic          s1_x_odd_r;
  logic          s1_x0_r;
  logic          s1_x1_r;
  logic          s1_y0_r;
  logic          s1_y1_r;
  logic          s1_y_odd_r;
  logic          s1_fe_r;

  rgb_t           res_first;
  rgb_t           res_last;
  logic [1:0]     n_res;
  logic [PB-1:0]  red_even;
  logic           q_full;
  logic           push;
  logic           s1_done;
  bnnd_pkg::pix_t push_data;
  bnnd_pkg::pix_t q_data;

  function automatic bnnd_pkg::pix_t mask_pix(rgb_t c, logic mode, logic last, logic fe);
    bnnd_pkg::pix_t p;
    p.red       = c.red;
    p.green     = c.green;
    p.blue      = c.blue;
    p.run_last  = last;
    p.frame_end = fe;
    if (!mode) begin
      unique case (c.own)
        OWN_RED: begin
          p.green = '0;
          p.blue  = '0;
        end
        OWN_GREEN: begin
          p.red  = '0;
          p.blue = '0;
        end
        OWN_BLUE: begin
          p.red   = '0;
          p.green = '0;
        end
        default: begin
          p.red   = '0;
          p.green = '0;
          p.blue  = '0;
        end
      endcase
    end
    return p;
  endfunction

  always_comb begin
    red_even  = s1_x0_r ? s1_r1_r : la_r;
    res_first = '{red: a, green: la_r, blue: s1_lc_r, own: OWN_RED};
    res_last  = '{red: a, green: s1_pix_r, blue: s1_lc_r, own: OWN_GREEN};
    n_res     = 2'd0;
    if (s1_y0_r) begin
      n_res = 2'd0;
    end else if (s1_y_odd_r) begin
      n_res = s1_y1_r ? 2'd2 : 2'd1;
      if (!s1_x_odd_r) begin
        res_first = '{red: red_even, green: a, blue: s1_pix_r, own: OWN_GREEN};
        res_last  = '{red: red_even, green: a, blue: s1_pix_r, own: OWN_BLUE};
      end
    end else if (!s1_x_odd_r) begin
      n_res    = s1_x0_r ? 2'd0 : 2'd1;
      res_last = '{red: s1_lc_r, green: s1_pix_r, blue: a, own: OWN_GREEN};
    end else begin
      n_res     = s1_x1_r ? 2'd2 : 2'd1;
      res_first = '{red: s1_pix_r, green: s1_lc_r, blue: la_r, own: OWN_GREEN};
      res_last  = '{red: s1_pix_r, green: s1_lc_r, blue: la_r, own: OWN_RED};
    end
  end

  assign push    = s1_v_r && (n_res != 2'd0) && !q_full;
  assign s1_done = s1_v_r &&
                   ((n_res == 2'd0) || (!q_full && ((n_res == 2'd1) || phase_r)));
  assign in_tready = !s1_v_r || s1_done;

  always_comb begin
    if ((n_res == 2'd2) && !phase_r) begin
      push_data = mask_pix(res_first, mode_r, 1'b0, 1'b0);
    end else begin
      push_data = mask_pix(res_last, mode_r, 1'b1, s1_fe_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      lc_r    <= '0;
      la_r    <= '0;
      s1_v_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        lc_r  <= v;
      end
      if (s1_done) begin
        la_r    <= a;
        phase_r <= 1'b0;
      end else if (push) begin
        phase_r <= 1'b1;
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_done) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (x == XW'(1)) begin
        r1_r <= v;
      end
      s1_pix_r   <= v;
      s1_lc_r    <= lc_r;
      s1_r1_r    <= r1_r;
      s1_x_odd_r <= x[0];
      s1_x0_r    <= (x == '0);
      s1_x1_r    <= (x == XW'(1));
      s1_y0_r    <= (y == '0);
      s1_y1_r    <= (y == HB'(1));
      s1_y_odd_r <= y[0];
      s1_fe_r    <= wrap && row_wrap;
    end
  end

  bnnd_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  assign out_tdata = {q_data.blue, q_data.green, q_data.red};
  assign out_tlast = q_data.run_last;
  assign out_tuser = q_data.frame_end;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the GRBG nearest-neighbour Bayer demosaic top level.
`timescale 1ns / 100ps
module tb;

  localparam int MAX_W    = bnnd_pkg::MAX_WIDTH_DEF;
  localparam int SETTLE   = 8;
  localparam int HOLD_AT  = 150;
  localparam int HOLD_LEN = 400;
  localparam int LIMIT    = 3000;
  localparam int CALM_LO  = 400;
  localparam int CALM_HI  = 800;

  typedef enum {OWN_RED, OWN_GREEN, OWN_BLUE} colour_t;
  typedef enum {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    bnnd_pkg::cfg_reg_t sel;
    logic [31:0]        value;
    logic [7:0]         pixel;
    int                 typed_n;
    bnnd_pkg::pix_t     typed0;
    bnnd_pkg::pix_t     typed1;
  } row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [7:0]                         in_tdata = '0;    // [7:0] raw_pixel
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [23:0]                        out_tdata;        // [7:0] red, [15:8] green, [23:16] blue
  logic                               out_tlast;
  logic                               out_tuser;        // [0] frame_end
  logic                               cfg_psel = 1'b0;
  logic                               cfg_penable = 1'b0;
  logic                               cfg_pwrite = 1'b0;
  logic [bnnd_pkg::CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [bnnd_pkg::CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [bnnd_pkg::CFG_DATA_BITS-1:0] cfg_prdata;
  logic                               cfg_pready;

  // predictor state
  logic [7:0]      line_mem [MAX_W];
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;
  int unsigned     line_fill = 0;
  logic [7:0]      west_px = '0;
  logic [7:0]      northwest_px = '0;
  logic [12:0]     cfg_width = bnnd_pkg::WIDTH_RST;
  logic [15:0]     cfg_height = bnnd_pkg::HEIGHT_RST;
  logic            cfg_mode = bnnd_pkg::MODE_RST;

  bnnd_pkg::pix_t rgb_due[$];
  bnnd_pkg::pix_t rgb_new[$];
  int   fail_cnt = 0;
  int   cyc = 0;
  int   quiet = 0;
  int   out_seen = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  bayer_nearest_neighbour_demosaic_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic bnnd_pkg::pix_t rgb(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic last,
                                         input logic fend);
    bnnd_pkg::pix_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.run_last = last;
    p.frame_end = fend;
    return p;
  endfunction

  function automatic bnnd_pkg::pix_t shade(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input colour_t own);
    if (!cfg_mode) begin
      if (own != OWN_RED) r = '0;
      if (own != OWN_GREEN) g = '0;
      if (own != OWN_BLUE) b = '0;
    end
    return rgb(r, g, b, 1'b0, 1'b0);
  endfunction

  function automatic int unsigned eff_width(input logic [12:0] w);
    if (w < 13'd2) return 2;
    if (int'(w) > MAX_W) return MAX_W;
    return int'(w);
  endfunction

  function automatic int unsigned eff_height(input logic [15:0] h);
    return (h < 16'd2) ? 2 : int'(h);
  endfunction

  function automatic bit at_frame_start();
    return (col_pos >= eff_width(cfg_width) || col_pos == 0) &&
           (row_pos >= eff_height(cfg_height) || row_pos == 0);
  endfunction

  // keep every line-buffer read on an entry already written
  function automatic logic [31:0] fit_width(input logic [31:0] req);
    int unsigned next_row;
    next_row = (row_pos >= eff_height(cfg_height)) ? 0 : row_pos;
    if (next_row != 0 && eff_width(req[12:0]) > line_fill) return line_fill;
    return req;
  endfunction

  function automatic bit idle_now();
    if (cyc >= CALM_LO && cyc < CALM_HI) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic demosaic_step(input logic [7:0] v);
    int unsigned w, h, x, y;
    logic [7:0] above, r1, lc, la;
    w = eff_width(cfg_width);
    h = eff_height(cfg_height);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    above = line_mem[x];
    r1 = line_mem[1];
    lc = west_px;
    la = northwest_px;
    if (y != 0) begin
      if (y % 2 == 1) begin
        if (y == 1) begin
          if (x % 2 == 0) rgb_new.push_back(shade(x > 0 ? la : r1, above, v, OWN_GREEN));
          else rgb_new.push_back(shade(above, la, lc, OWN_RED));
        end
        if (x % 2 == 0) rgb_new.push_back(shade(x > 0 ? la : r1, above, v, OWN_BLUE));
        else rgb_new.push_back(shade(above, v, lc, OWN_GREEN));
      end else if (x % 2 == 0) begin
        if (x > 0) rgb_new.push_back(shade(lc, v, above, OWN_GREEN));
      end else begin
        if (x == 1) rgb_new.push_back(shade(v, lc, la, OWN_GREEN));
        rgb_new.push_back(shade(v, lc, la, OWN_RED));
      end
    end
    if (rgb_new.size() > 0) begin
      rgb_new[rgb_new.size()-1].run_last = 1'b1;
      if (x == w - 1 && y == h - 1) rgb_new[rgb_new.size()-1].frame_end = 1'b1;
    end
    west_px = v;
    northwest_px = above;
    line_mem[x] = v;
    if (x + 1 > line_fill) line_fill = x + 1;
    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic push_pixel(input logic [7:0] v, input bit typed);
    while (idle_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    demosaic_step(v);
    if (!typed) foreach (rgb_new[i]) rgb_due.push_back(rgb_new[i]);
    rgb_new.delete();
  endtask

  task automatic reconfigure(input bnnd_pkg::cfg_reg_t sel, input logic [31:0] value);
    logic [31:0] want;
    logic [31:0] got;
    in_tvalid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (sel)
      bnnd_pkg::REG_IMAGE_WIDTH: begin
        cfg_width = value[12:0];
        want = {19'd0, value[12:0]};
      end
      bnnd_pkg::REG_IMAGE_HEIGHT: begin
        cfg_height = value[15:0];
        want = {16'd0, value[15:0]};
      end
      bnnd_pkg::REG_INTERP_MODE: begin
        cfg_mode = value[0];
        want = {31'd0, value[0]};
      end
      default: want = '0;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== want) begin
      $error("%s readback: expected %0h, got %0h", sel.name(), want, got);
      fail_cnt++;
    end
  endtask

  function automatic row_t cfg_row(input bnnd_pkg::cfg_reg_t sel, input logic [31:0] value);
    row_t r;
    r.kind = ROW_CFG;
    r.sel = sel;
    r.value = value;
    r.pixel = '0;
    r.typed_n = -1;
    r.typed0 = '0;
    r.typed1 = '0;
    return r;
  endfunction

  function automatic row_t typed_row(input logic [7:0] p, input int n,
                                     input bnnd_pkg::pix_t e0, input bnnd_pkg::pix_t e1);
    row_t r;
    r = cfg_row(bnnd_pkg::REG_IMAGE_WIDTH, '0);
    r.kind = ROW_PIX;
    r.pixel = p;
    r.typed_n = n;
    r.typed0 = e0;
    r.typed1 = e1;
    return r;
  endfunction

  function automatic row_t pix_row(input logic [7:0] p);
    return typed_row(p, -1, '0, '0);
  endfunction

  // output side: check results, stall at random, hold off once for a long stretch
  always @(posedge clk) begin : drain
    bnnd_pkg::pix_t want;
    if (rst_n && out_tvalid && out_tready) begin
      out_seen++;
      if (rgb_due.size() == 0) begin
        $error("unexpected pixel: tdata %0h tlast %0b tuser %0b",
               out_tdata, out_tlast, out_tuser);
        fail_cnt++;
      end else begin
        want = rgb_due.pop_front();
        check_field("red", want.red, out_tdata[7:0]);
        check_field("green", want.green, out_tdata[15:8]);
        check_field("blue", want.blue, out_tdata[23:16]);
        check_field("run_last", {7'd0, want.run_last}, {7'd0, out_tlast});
        check_field("frame_end", {7'd0, want.frame_end}, {7'd0, out_tuser});
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && out_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    cyc++;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet = 0;
    else quiet++;
    if (quiet >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t plan[$];
    int   rand_items;
    int   n;
    int   big_w;
    bit   big_done;
    bit   tall_done;
    rand_items = 0;
    big_w = 0;
    big_done = 1'b0;
    tall_done = 1'b0;

    // undersized frame in plain mode
    plan.push_back(cfg_row(bnnd_pkg::REG_IMAGE_WIDTH, 1));
    plan.push_back(cfg_row(bnnd_pkg::REG_IMAGE_HEIGHT, 0));
    plan.push_back(cfg_row(bnnd_pkg::REG_INTERP_MODE, 0));
    plan.push_back(typed_row(8'h3C, 0, '0, '0));
    plan.push_back(typed_row(8'hFF, 0, '0, '0));
    plan.push_back(typed_row(8'h00, 2, rgb(8'h00, 8'h3C, 8'h00, 1'b0, 1'b0),
                             rgb(8'h00, 8'h00, 8'h00, 1'b1, 1'b0)));
    plan.push_back(typed_row(8'hC3, 2, rgb(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0),
                             rgb(8'h00, 8'hC3, 8'h00, 1'b1, 1'b1)));
    // 4x4 frame, mode switch in row 1, width cut in row 3
    plan.push_back(cfg_row(bnnd_pkg::REG_INTERP_MODE, 1));
    plan.push_back(cfg_row(bnnd_pkg::REG_IMAGE_WIDTH, 4));
    plan.push_back(cfg_row(bnnd_pkg::REG_IMAGE_HEIGHT, 4));
    plan.push_back(pix_row(8'h00)); plan.push_back(pix_row(8'hFF));
    plan.push_back(pix_row(8'h81)); plan.push_back(pix_row(8'h7E));
    plan.push_back(pix_row(8'h12)); plan.push_back(pix_row(8'hED));
    plan.push_back(cfg_row(bnnd_pkg::REG_INTERP_MODE, 0));
    plan.push_back(pix_row(8'h34)); plan.push_back(pix_row(8'hCB));
    plan.push_back(pix_row(8'hFF)); plan.push_back(pix_row(8'h00));
    plan.push_back(pix_row(8'h56)); plan.push_back(pix_row(8'hA9));
    plan.push_back(pix_row(8'h9C)); plan.push_back(pix_row(8'h63));
    plan.push_back(pix_row(8'h0F));
    plan.push_back(cfg_row(bnnd_pkg::REG_IMAGE_WIDTH, 2));
    plan.push_back(pix_row(8'hF0)); plan.push_back(pix_row(8'h1E));
    // height cut below the current row wraps to a new frame
    plan.push_back(pix_row(8'h55)); plan.push_back(pix_row(8'hAA));
    plan.push_back(pix_row(8'hFF)); plan.push_back(pix_row(8'h01));
    plan.push_back(cfg_row(bnnd_pkg::REG_IMAGE_HEIGHT, 2));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        reconfigure(plan[i].sel, plan[i].value);
      end else begin
        push_pixel(plan[i].pixel, plan[i].typed_n >= 0);
        if (plan[i].typed_n > 0) rgb_due.push_back(plan[i].typed0);
        if (plan[i].typed_n > 1) rgb_due.push_back(plan[i].typed1);
      end
    end

    while (rand_items < 450) begin
      if (!big_done && rand_items >= 150) begin
        big_done = 1'b1;
        reconfigure(bnnd_pkg::REG_IMAGE_HEIGHT, 2);
        while (!at_frame_start()) push_pixel(8'($urandom_range(255)), 1'b0);
        big_w = int'($urandom_range(120, 60));
        reconfigure(bnnd_pkg::REG_IMAGE_WIDTH, fit_width(big_w));
        reconfigure(bnnd_pkg::REG_INTERP_MODE, $urandom_range(1));
        repeat (2 * big_w) push_pixel(8'($urandom_range(255)), 1'b0);
        rand_items += 2 * big_w;
      end else if (!tall_done && rand_items >= 300) begin
        tall_done = 1'b1;
        reconfigure(bnnd_pkg::REG_IMAGE_HEIGHT, 32'hFFFF);
        reconfigure(bnnd_pkg::REG_IMAGE_WIDTH, fit_width($urandom_range(10, 2)));
        repeat (40) push_pixel(8'($urandom_range(255)), 1'b0);
        rand_items += 40;
        reconfigure(bnnd_pkg::REG_IMAGE_HEIGHT, $urandom_range(6, 2));
      end else begin
        if ($urandom_range(1))
          reconfigure(bnnd_pkg::REG_IMAGE_HEIGHT,
                      ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(6, 2));
        if ($urandom_range(1)) reconfigure(bnnd_pkg::REG_INTERP_MODE, $urandom_range(1));
        if ($urandom_range(1))
          reconfigure(bnnd_pkg::REG_IMAGE_WIDTH, fit_width(($urandom_range(9) == 0) ?
                                                 $urandom_range(1) : $urandom_range(10, 2)));
        if ($urandom_range(3) != 0) begin
          do begin
            push_pixel(8'($urandom_range(255)), 1'b0);
            rand_items++;
          end while (!at_frame_start());
        end else begin
          n = int'($urandom_range(30, 1));
          repeat (n) push_pixel(8'($urandom_range(255)), 1'b0);
          rand_items += n;
        end
      end
    end

    in_tvalid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (fail_cnt == 0 && rgb_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
